// ----- rtl/wms_pkg.sv -----
// shared types and constants for the weighted mode selector
// used by every rtl file of the block except wms_ram; depends on nothing

package wms_pkg;

  // default sizes for the top-level parameters
  localparam int MAX_MODES_DEF  = 64;
  localparam int WIDTH_BITS_DEF = 32;

  // fixed field widths of the ports
  localparam int COUNT_BITS  = 7;
  localparam int SLOT_BITS   = 6;
  localparam int ENTRY_BITS  = 32;
  localparam int DRAW_BITS   = 16;
  localparam int WEIGHT_FRAC = 16;
  localparam int WEIGHT_BITS = 48;

  // apb port sizes
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  // register index codes (paddr[3:2])
  localparam logic [1:0] REG_MODE_COUNT = 2'd0;

  // request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PICK  = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_RD,
    ST_WR_UPD,
    ST_SUM_SCAN,
    ST_PICK_SCAN,
    ST_DIV
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic wr_read;
    logic wr_update;
    logic scan_start;
    logic scan_step;
    logic pick_check;
    logic sum_load;
    logic div_start;
    logic div_step;
    logic emit;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic div_done;
  } ctl_status_t;

endpackage

// ----- rtl/wms_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies

module wms_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/wms_datapath.sv -----
// datapath: width table, unlocked sum, scan pipeline, serial divider, result registers
// depends on wms_pkg and wms_ram

module wms_datapath #(
  parameter int MaxModes  = wms_pkg::MAX_MODES_DEF,
  parameter int WidthBits = wms_pkg::WIDTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wms_pkg::ctl_cmd_t                   cmd,
  output wms_pkg::ctl_status_t                status,
  input  logic [wms_pkg::COUNT_BITS-1:0]      mode_count,
  input  logic [wms_pkg::SLOT_BITS-1:0]       entry_index,
  input  logic [wms_pkg::ENTRY_BITS-1:0]      entry_width,
  input  logic                                entry_locked,
  input  logic [wms_pkg::DRAW_BITS-1:0]       uniform_draw,
  output logic [wms_pkg::COUNT_BITS-1:0]      picked_mode,
  output logic                                found,
  output logic [wms_pkg::WEIGHT_BITS-1:0]     jacobian_weight,
  output logic                                done
);

  localparam int IDX_W = $clog2(MaxModes);
  localparam int CNT_W = $clog2(MaxModes + 1);
  localparam int SUM_W = WidthBits + IDX_W;
  localparam int TGT_W = SUM_W + wms_pkg::DRAW_BITS;
  localparam int QW    = SUM_W + wms_pkg::WEIGHT_FRAC;
  localparam int DCW   = $clog2(QW + 1);
  localparam int CB    = wms_pkg::COUNT_BITS;
  localparam int WB    = wms_pkg::WEIGHT_BITS;

  // captured request
  logic [wms_pkg::SLOT_BITS-1:0] slot_q;
  logic [WidthBits-1:0]          wr_w;
  logic                          wr_lk;
  logic [TGT_W-1:0]              target;

  // table state
  logic [MaxModes-1:0] valid;
  logic [SUM_W-1:0]    sum;

  // ram ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WidthBits:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WidthBits:0]   ram_rdata;
  logic                 rd_valid;

  // scan state
  logic [CNT_W-1:0]     scan_addr;
  logic                 rd_pend;
  logic [CNT_W-1:0]     rd_idx;
  logic [SUM_W-1:0]     acc;
  logic                 hit_flag;
  logic [CNT_W-1:0]     hit_idx;
  logic [WidthBits-1:0] hit_w;

  // divider state
  logic [WidthBits-1:0] rem;
  logic [QW-1:0]        qd;
  logic [DCW-1:0]       dcnt;

  // helper signals
  logic [CB+CNT_W-1:0]               mc_ext;
  logic [CNT_W-1:0]                  live_n;
  logic [wms_pkg::SLOT_BITS+IDX_W-1:0] slot_ext;
  logic [IDX_W-1:0]                  slot_addr;
  logic [wms_pkg::ENTRY_BITS+WidthBits-1:0] w_in_ext;
  logic [WidthBits-1:0]              ent_w;
  logic                              ent_lk;
  logic [SUM_W-1:0]                  ent_w_ext;
  logic [SUM_W-1:0]                  cum_new;
  logic                              hit_now;
  logic                              issue_rd;
  logic                              slot_ok;
  logic                              slot_live;
  logic [SUM_W-1:0]                  old_part;
  logic [SUM_W-1:0]                  new_part;
  logic [WidthBits:0]                rem_sh;
  logic [WidthBits:0]                diff;
  logic                              ge;
  logic [QW+WB-1:0]                  q_ext;
  logic [WB-1:0]                     q_sat;
  logic [CNT_W+CB-1:0]               hit_idx_ext;
  logic [CNT_W+CB-1:0]               live_n_ext;

  // effective mode count, clipped to the table depth
  assign mc_ext = {{CNT_W{1'b0}}, mode_count};
  assign live_n = (mode_count > MaxModes) ? CNT_W'(MaxModes) : mc_ext[CNT_W-1:0];

  // slot and width fitted to the table
  assign slot_ext  = {{IDX_W{1'b0}}, slot_q};
  assign slot_addr = slot_ext[IDX_W-1:0];
  assign w_in_ext  = {{WidthBits{1'b0}}, entry_width};
  assign slot_ok   = slot_q < MaxModes;
  assign slot_live = slot_q < live_n;

  // entry read back; never-written entries read as zero and unlocked
  assign ent_w     = rd_valid ? ram_rdata[WidthBits-1:0] : '0;
  assign ent_lk    = rd_valid & ram_rdata[WidthBits];
  assign ent_w_ext = {{IDX_W{1'b0}}, ent_w};
  assign cum_new   = acc + ent_w_ext;
  assign hit_now   = cmd.pick_check && rd_pend && !hit_flag && !ent_lk &&
                     ({cum_new, {wms_pkg::DRAW_BITS{1'b0}}} >= target);
  assign issue_rd  = cmd.scan_step && !hit_flag && (scan_addr < live_n);

  // sum update terms for a table write
  assign old_part = ent_lk ? '0 : ent_w_ext;
  assign new_part = wr_lk ? '0 : {{IDX_W{1'b0}}, wr_w};

  // ram port muxing
  assign ram_raddr = cmd.wr_read ? slot_addr : scan_addr[IDX_W-1:0];
  assign ram_we    = cmd.wr_update && slot_ok;
  assign ram_waddr = slot_addr;
  assign ram_wdata = {wr_lk, wr_w};

  wms_ram #(
    .DATA_W (WidthBits + 1),
    .DEPTH  (MaxModes)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status to the controller
  assign status.scan_done = hit_flag || ((scan_addr >= live_n) && !rd_pend);
  assign status.hit       = hit_flag;
  assign status.div_done  = (dcnt == '0);

  // request capture and pick target
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_q <= entry_index;
      wr_w   <= w_in_ext[WidthBits-1:0];
      wr_lk  <= entry_locked;
      target <= {{SUM_W{1'b0}}, uniform_draw} * {{wms_pkg::DRAW_BITS{1'b0}}, sum};
    end
  end

  // valid bits track which entries have been written
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[slot_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[ram_raddr];
  end

  // running sum of unlocked in-use widths
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (cmd.sum_load) begin
      sum <= acc;
    end else if (cmd.wr_update && slot_ok && slot_live) begin
      sum <= sum - old_part + new_part;
    end
  end

  // scan pipeline: one read issued per cycle, its data processed in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_pend   <= 1'b0;
      hit_flag  <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_addr <= '0;
      rd_pend   <= 1'b0;
      hit_flag  <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_pend <= issue_rd;
      if (issue_rd) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (hit_now) begin
        hit_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      acc <= '0;
    end else if (cmd.scan_step) begin
      rd_idx <= scan_addr;
      if (rd_pend && !hit_flag && !ent_lk) begin
        acc <= cum_new;
      end
      if (hit_now) begin
        hit_idx <= rd_idx;
        hit_w   <= ent_w;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem, qd[QW-1]};
  assign ge     = rem_sh >= {1'b0, hit_w};
  assign diff   = rem_sh - {1'b0, hit_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dcnt <= DCW'(QW);
    end else if (cmd.div_step && (dcnt != '0)) begin
      dcnt <= dcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      qd  <= {sum, {wms_pkg::WEIGHT_FRAC{1'b0}}};
    end else if (cmd.div_step && (dcnt != '0)) begin
      rem <= ge ? diff[WidthBits-1:0] : rem_sh[WidthBits-1:0];
      qd  <= {qd[QW-2:0], ge};
    end
  end

  // quotient saturation and index fitting
  assign q_ext       = {{WB{1'b0}}, qd};
  assign q_sat       = (|q_ext[QW+WB-1:WB]) ? '1 : q_ext[WB-1:0];
  assign hit_idx_ext = {{CB{1'b0}}, hit_idx};
  assign live_n_ext  = {{CB{1'b0}}, live_n};

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (hit_flag) begin
        picked_mode     <= hit_idx_ext[CB-1:0];
        found           <= 1'b1;
        jacobian_weight <= (hit_w == '0) ? '1 : q_sat;
      end else begin
        picked_mode     <= live_n_ext[CB-1:0];
        found           <= 1'b0;
        jacobian_weight <= '0;
      end
    end
  end

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_div_needs_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> hit_flag)
    else $error("division started without a selected mode");

  a_hit_sticky: assert property (@(posedge clk) disable iff (rst)
    hit_flag && !cmd.scan_start |=> hit_flag)
    else $error("selection lost before next scan");

endmodule

// ----- rtl/wms_ctrl.sv -----
// controller state machine: sequences writes, sum rebuilds, scans and division
// depends on wms_pkg

module wms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 func,
  input  logic                 cfg_write,
  input  wms_pkg::ctl_status_t status,
  output wms_pkg::ctl_cmd_t    cmd,
  output logic                 busy
);

  wms_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      wms_pkg::ST_IDLE: begin
        if (cfg_write) begin
          cmd.scan_start = 1'b1;
          state_next     = wms_pkg::ST_SUM_SCAN;
        end else if (start) begin
          cmd.load = 1'b1;
          if (func == wms_pkg::FUNC_PICK) begin
            cmd.scan_start = 1'b1;
            state_next     = wms_pkg::ST_PICK_SCAN;
          end else begin
            state_next = wms_pkg::ST_WR_RD;
          end
        end
      end
      wms_pkg::ST_WR_RD: begin
        cmd.wr_read = 1'b1;
        state_next  = wms_pkg::ST_WR_UPD;
      end
      wms_pkg::ST_WR_UPD: begin
        cmd.wr_update = 1'b1;
        state_next    = wms_pkg::ST_IDLE;
      end
      wms_pkg::ST_SUM_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          cmd.sum_load = 1'b1;
          state_next   = wms_pkg::ST_IDLE;
        end
      end
      wms_pkg::ST_PICK_SCAN: begin
        cmd.scan_step  = 1'b1;
        cmd.pick_check = 1'b1;
        if (status.scan_done) begin
          if (status.hit) begin
            cmd.div_start = 1'b1;
            state_next    = wms_pkg::ST_DIV;
          end else begin
            cmd.emit   = 1'b1;
            state_next = wms_pkg::ST_IDLE;
          end
        end
      end
      wms_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          cmd.emit   = 1'b1;
          state_next = wms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wms_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != wms_pkg::ST_IDLE) || cfg_write;

  // checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> (state == wms_pkg::ST_WR_RD) || (state == wms_pkg::ST_PICK_SCAN))
    else $error("accepted request did not start work");

  a_write_order: assert property (@(posedge clk) disable iff (rst)
    state == wms_pkg::ST_WR_UPD |-> $past(state) == wms_pkg::ST_WR_RD)
    else $error("table update without prior read");

endmodule

// ----- rtl/weighted_mode_selector_top.sv -----
// top level of the weighted mode selector: apb register, controller and datapath
// depends on wms_pkg, wms_ctrl, wms_datapath (and wms_ram below it)
//
//   channel   handshake               payload
//   request   start & !busy           func, entry_index, entry_width, entry_locked,
//                                     uniform_draw
//   result    done (one cycle)        picked_mode, found, jacobian_weight
//   config    psel&penable&pwrite     paddr, pwdata, prdata (pready tied high)
//
// a write request steps through the accept, table read and update states
// a pick walks the table (one entry per cycle through the ram read port) and,
// when a mode is found, then runs the serial divider
// a mode_count write keeps busy high while the unlocked sum is
// rebuilt by a walk of the table
// rst is synchronous; the table reads as zero until written, no clearing pass
// results are strobed on done for one cycle and cannot be stalled

module weighted_mode_selector_top #(
  parameter int MaxModes  = wms_pkg::MAX_MODES_DEF,
  parameter int WidthBits = wms_pkg::WIDTH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               func,
  input  logic [wms_pkg::SLOT_BITS-1:0]      entry_index,
  input  logic [wms_pkg::ENTRY_BITS-1:0]     entry_width,
  input  logic                               entry_locked,
  input  logic [wms_pkg::DRAW_BITS-1:0]      uniform_draw,
  // result channel
  output logic                               done,
  output logic [wms_pkg::COUNT_BITS-1:0]     picked_mode,
  output logic                               found,
  output logic [wms_pkg::WEIGHT_BITS-1:0]    jacobian_weight,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wms_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [wms_pkg::DATA_BITS-1:0]      pwdata,
  output logic [wms_pkg::DATA_BITS-1:0]      prdata,
  output logic                               pready
);

  logic [wms_pkg::COUNT_BITS-1:0] mode_count;
  logic                           cfg_write;
  logic                           reg_hit;
  wms_pkg::ctl_cmd_t              cmd;
  wms_pkg::ctl_status_t           status;

  // apb register decode
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[3:2] == wms_pkg::REG_MODE_COUNT);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_count <= '0;
    end else if (cfg_write) begin
      mode_count <= pwdata[wms_pkg::COUNT_BITS-1:0];
    end
  end

  // read back
  assign prdata = reg_hit ?
                  {{(wms_pkg::DATA_BITS - wms_pkg::COUNT_BITS){1'b0}}, mode_count} : '0;

  wms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .cfg_write (cfg_write),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  wms_datapath #(
    .MaxModes  (MaxModes),
    .WidthBits (WidthBits)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .mode_count      (mode_count),
    .entry_index     (entry_index),
    .entry_width     (entry_width),
    .entry_locked    (entry_locked),
    .uniform_draw    (uniform_draw),
    .picked_mode     (picked_mode),
    .found           (found),
    .jacobian_weight (jacobian_weight),
    .done            (done)
  );

endmodule

// ----- sim/weighted_mode_selector_top_test.sv -----
// self-checking testbench for the weighted mode selector: directed and random requests
// depends on wms_pkg and weighted_mode_selector_top; predicts every pick on its own

module weighted_mode_selector_top_test;
  import wms_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int CLK_PERIOD    = 2 * CLK_HALF;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 150;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int REPORT_LIMIT  = 10;
  localparam int TABLE_DEPTH   = MAX_MODES_DEF;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 157;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_SAT = '1;
  localparam logic [ENTRY_BITS-1:0]  WIDTH_MAX  = '1;
  localparam logic [DRAW_BITS-1:0]   DRAW_MAX   = '1;
  localparam logic [1:0]             REG_UNUSED = 2'd1;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  mode;
    logic                   found;
    logic [WEIGHT_BITS-1:0] weight;
  } pick_result_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   func;
  logic [SLOT_BITS-1:0]   entry_index;
  logic [ENTRY_BITS-1:0]  entry_width;
  logic                   entry_locked;
  logic [DRAW_BITS-1:0]   uniform_draw;
  logic                   done;
  logic [COUNT_BITS-1:0]  picked_mode;
  logic                   found;
  logic [WEIGHT_BITS-1:0] jacobian_weight;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_BITS-1:0]   paddr;
  logic [DATA_BITS-1:0]   pwdata;
  logic [DATA_BITS-1:0]   prdata;
  logic                   pready;

  // predicted table, lock flags, unlocked sum and count register
  logic [ENTRY_BITS-1:0] width_tab [TABLE_DEPTH];
  logic                  lock_tab [TABLE_DEPTH];
  logic [63:0]           unlocked_total;
  logic [COUNT_BITS-1:0] count_setting;

  pick_result_t pending_picks[$];
  int           mismatch_count;
  logic         steady_flow;

  weighted_mode_selector_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .entry_index     (entry_index),
    .entry_width     (entry_width),
    .entry_locked    (entry_locked),
    .uniform_draw    (uniform_draw),
    .done            (done),
    .picked_mode     (picked_mode),
    .found           (found),
    .jacobian_weight (jacobian_weight),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // hard stop on a hung run
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("FAIL");
    $finish;
  end

  // entries in use, the count register clamped to the table size
  function automatic int live_entries();
    return (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting);
  endfunction

  // sum of unlocked widths below the live count
  function automatic void rebuild_total();
    unlocked_total = '0;
    for (int i = 0; i < live_entries(); i++)
      if (!lock_tab[i]) unlocked_total += width_tab[i];
  endfunction

  // table write, keeping the unlocked sum current for live slots
  function automatic void store_entry(input logic [SLOT_BITS-1:0] slot,
                                      input logic [ENTRY_BITS-1:0] w, input logic lk);
    if (int'(slot) < live_entries()) begin
      if (!lock_tab[slot]) unlocked_total -= width_tab[slot];
      if (!lk) unlocked_total += w;
    end
    width_tab[slot] = w;
    lock_tab[slot]  = lk;
  endfunction

  // roulette walk: first unlocked mode whose running sum reaches draw * total
  function automatic pick_result_t select_mode(input logic [DRAW_BITS-1:0] draw);
    pick_result_t r;
    logic [63:0]  target;
    logic [63:0]  cum;
    logic [63:0]  quotient;
    int           n;
    n        = live_entries();
    target   = 64'(draw) * unlocked_total;
    cum      = '0;
    r.mode   = COUNT_BITS'(n);
    r.found  = 1'b0;
    r.weight = '0;
    for (int i = 0; i < n; i++) begin
      if (!lock_tab[i]) begin
        cum += width_tab[i];
        if ((cum << DRAW_BITS) >= target) begin
          r.mode  = COUNT_BITS'(i);
          r.found = 1'b1;
          if (width_tab[i] == '0) begin
            r.weight = WEIGHT_SAT;
          end else begin
            quotient = (unlocked_total << WEIGHT_FRAC) / width_tab[i];
            r.weight = (quotient > 64'(WEIGHT_SAT)) ? WEIGHT_SAT : quotient[WEIGHT_BITS-1:0];
          end
          return r;
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // result checker: every done strobe against the oldest pending pick
  always @(posedge clk) begin : check_results
    pick_result_t want;
    if (!rst && done) begin
      if (pending_picks.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: mode %0d found %0d weight %h",
                                picked_mode, found, jacobian_weight));
      end else begin
        want = pending_picks.pop_front();
        if (picked_mode !== want.mode || found !== want.found ||
            jacobian_weight !== want.weight)
          flag_mismatch($sformatf(
            "pick mismatch: expected mode %0d found %0d weight %h, got %0d %0d %h",
            want.mode, want.found, want.weight, picked_mode, found, jacobian_weight));
      end
    end
  end

  // random gap after a request: mostly none or short, a few long
  task automatic idle_gap();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 55) gap = 0;
    else if (roll < 90)           gap = $urandom_range(1, 3);
    else if (roll < 98)           gap = $urandom_range(8, 40);
    else                          gap = $urandom_range(41, 160);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drive one request, wait for acceptance, update the prediction
  task automatic send_request(input logic f, input logic [SLOT_BITS-1:0] idx,
                              input logic [ENTRY_BITS-1:0] w, input logic lk,
                              input logic [DRAW_BITS-1:0] draw);
    @(negedge clk);
    start        <= 1'b1;
    func         <= f;
    entry_index  <= idx;
    entry_width  <= w;
    entry_locked <= lk;
    uniform_draw <= draw;
    do @(posedge clk); while (busy);
    if (f == FUNC_WRITE) store_entry(idx, w, lk);
    else pending_picks.push_back(select_mode(draw));
    idle_gap();
  endtask

  // register write once the block has drained, then read back the count
  task automatic write_register(input logic [1:0] reg_idx, input logic [DATA_BITS-1:0] value);
    logic [DATA_BITS-1:0] readback;
    @(negedge clk);
    start <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    // setup and access phases of the write
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_MODE_COUNT) begin
      count_setting = value[COUNT_BITS-1:0];
      rebuild_total();
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // read back the count register
    @(negedge clk);
    psel  <= 1'b1;
    paddr <= {REG_MODE_COUNT, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[COUNT_BITS-1:0] !== count_setting)
      flag_mismatch($sformatf("mode_count readback: expected %0d, got %0d",
                              count_setting, readback[COUNT_BITS-1:0]));
  endtask

  // picks on the empty table after reset
  task automatic test_empty_table();
    send_request(FUNC_PICK, '1, WIDTH_MAX, 1'b1, '0);
    send_request(FUNC_PICK, '0, '0, 1'b0, DRAW_MAX);
  endtask

  // extreme widths and draws, zero width and large weight saturation, write past count
  task automatic test_table_edges();
    write_register(REG_MODE_COUNT, 32'hFFFF_FF83);
    send_request(FUNC_WRITE, 6'd0, '0, 1'b0, DRAW_MAX);
    send_request(FUNC_WRITE, 6'd1, WIDTH_MAX, 1'b0, '0);
    send_request(FUNC_WRITE, 6'd2, WIDTH_MAX, 1'b1, '0);
    send_request(FUNC_WRITE, '1, WIDTH_MAX, 1'b0, '0);
    send_request(FUNC_PICK, '0, '0, 1'b0, '0);
    send_request(FUNC_PICK, '0, '0, 1'b0, DRAW_MAX);
    send_request(FUNC_WRITE, 6'd0, 32'd1, 1'b0, '0);
    send_request(FUNC_PICK, '1, WIDTH_MAX, 1'b1, '0);
    send_request(FUNC_PICK, '0, '0, 1'b0, 16'h8000);
  endtask

  // all modes locked, unknown register, count above the table size
  task automatic test_locks_and_count();
    send_request(FUNC_WRITE, 6'd0, 32'd7, 1'b1, '0);
    send_request(FUNC_WRITE, 6'd1, WIDTH_MAX, 1'b1, '0);
    send_request(FUNC_PICK, '0, '0, 1'b0, 16'h1234);
    write_register(REG_UNUSED, 32'h0000_0005);
    send_request(FUNC_PICK, '0, '0, 1'b0, DRAW_MAX);
    write_register(REG_MODE_COUNT, 32'h0000_007F);
    send_request(FUNC_PICK, '0, '0, 1'b0, DRAW_MAX);
    send_request(FUNC_PICK, '0, '0, 1'b0, '0);
    send_request(FUNC_WRITE, '1, WIDTH_MAX, 1'b1, '0);
    send_request(FUNC_PICK, '0, '0, 1'b0, DRAW_MAX);
    write_register(REG_MODE_COUNT, 32'h0000_0040);
  endtask

  // random requests under a series of count settings
  task automatic test_random_phases();
    int                    cnt;
    int                    n;
    int                    roll;
    logic [DATA_BITS-1:0]  noise;
    logic                  f;
    logic [SLOT_BITS-1:0]  idx;
    logic [ENTRY_BITS-1:0] w;
    logic                  lk;
    logic [DRAW_BITS-1:0]  draw;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       cnt = 1;
        1:       cnt = 2;
        2:       cnt = 0;
        3:       cnt = 64;
        4:       cnt = 127;
        5:       cnt = 9;
        default: cnt = $urandom_range(0, 127);
      endcase
      noise = $urandom();
      write_register(REG_MODE_COUNT, {noise[DATA_BITS-1:COUNT_BITS], COUNT_BITS'(cnt)});
      steady_flow = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        n   = live_entries();
        f   = ($urandom_range(0, 99) < 40) ? FUNC_PICK : FUNC_WRITE;
        idx = (n > 0 && $urandom_range(0, 3) != 0) ? SLOT_BITS'($urandom_range(0, n - 1))
                                                   : SLOT_BITS'($urandom());
        roll = $urandom_range(0, 9);
        if (roll == 0)     w = '0;
        else if (roll == 1) w = WIDTH_MAX;
        else if (roll < 5)  w = ENTRY_BITS'($urandom_range(0, 255));
        else                w = $urandom();
        lk   = ($urandom_range(0, 4) == 0);
        roll = $urandom_range(0, 11);
        if (roll == 0)      draw = '0;
        else if (roll == 1) draw = DRAW_MAX;
        else                draw = DRAW_BITS'($urandom());
        send_request(f, idx, w, lk, draw);
      end
    end
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    func           = FUNC_WRITE;
    entry_index    = '0;
    entry_width    = '0;
    entry_locked   = 1'b0;
    uniform_draw   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    steady_flow    = 1'b0;
    count_setting  = '0;
    unlocked_total = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      width_tab[i] = '0;
      lock_tab[i]  = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_table_edges();
    test_locks_and_count();
    test_random_phases();

    @(negedge clk);
    start <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- weighted_mode_selector_top.f -----
rtl/wms_pkg.sv
rtl/wms_ram.sv
rtl/wms_datapath.sv
rtl/wms_ctrl.sv
rtl/weighted_mode_selector_top.sv
sim/weighted_mode_selector_top_test.sv
